/* design/ps2_mouse_cursor_tracker_assert.svh */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker assertion macros
// Shared property wrappers, clocked on the rising edge, muted during reset.
// ----------------------------------------------------------------------------
`ifndef PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH
`define PS2_MOUSE_CURSOR_TRACKER_ASSERT_SVH

// Check that a condition implies another in the same cycle.
`define PMCT_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the next cycle.
`define PMCT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pmct_pkg.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker package
// Item types, packet type, screen limits, reset values and the clamp helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pmct_pkg;

  // Input item: one controller byte with its source flag
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       from_mouse;
  } pmct_in_t;

  // Result item: one cursor move report
  typedef struct packed {
    logic [6:0] old_col;
    logic [4:0] old_row;
    logic [6:0] new_col;
    logic [4:0] new_row;
    logic [7:0] button_byte;
    logic [2:0] changed_buttons;
  } pmct_out_t;

  // Complete three-byte mouse packet
  typedef struct packed {
    logic [7:0] btn;
    logic [7:0] dx;
    logic [7:0] dy;
  } pmct_pkt_t;

  // Effective (already limited) screen size
  typedef struct packed {
    logic [7:0] cols;
    logic [5:0] rows;
  } pmct_scr_t;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_SCREEN_COLS = 1'b0,
    CFG_SCREEN_ROWS = 1'b1
  } pmct_cfg_e;

  localparam logic [7:0] COLS_RESET = 8'd80;
  localparam logic [5:0] ROWS_RESET = 6'd25;
  localparam logic [7:0] COLS_MAX   = 8'd128;
  localparam logic [5:0] ROWS_MAX   = 6'd32;
  localparam logic [6:0] COL_RESET  = 7'd40;
  localparam logic [4:0] ROW_RESET  = 5'd12;
  localparam logic [1:0] LAST_BYTE  = 2'd2;
  localparam int unsigned XSIGN_BIT = 4;
  localparam int unsigned YSIGN_BIT = 5;

  // Clamp a signed position into 0 .. limit-1 (limit is 1..128)
  function automatic logic [6:0] clamp_pos(logic signed [9:0] v, logic [7:0] limit);
    logic [7:0] top;
    top = limit - 8'd1;
    if (v[9]) begin
      clamp_pos = 7'd0;
    end else if (v[8:0] >= {1'b0, limit}) begin
      clamp_pos = top[6:0];
    end else begin
      clamp_pos = v[6:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/pmct_front.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker front end
// Drops non-mouse bytes and gathers mouse bytes into three-byte packets.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pmct_front (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire pmct_pkg::pmct_in_t  in_data_i,
  output logic                     push_o,
  output pmct_pkg::pmct_pkt_t      pkt_o,
  input  wire logic                full_i
);

  logic       accept;
  logic       take;
  logic [1:0] idx_q, idx_d;
  logic [7:0] b0_q, b1_q;

  // Stall while the packet queue has no room
  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign take       = accept && in_data_i.from_mouse;

  // Push on the third mouse byte
  assign push_o    = take && (idx_q == pmct_pkg::LAST_BYTE);
  assign pkt_o.btn = b0_q;
  assign pkt_o.dx  = b1_q;
  assign pkt_o.dy  = in_data_i.rx_byte;

  // Advance byte position
  always_comb begin
    idx_d = idx_q;
    if (take) begin
      idx_d = (idx_q == pmct_pkg::LAST_BYTE) ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // Hold the first two packet bytes
  always_ff @(posedge clk_i) begin
    if (take && idx_q == 2'd0) begin
      b0_q <= in_data_i.rx_byte;
    end
    if (take && idx_q == 2'd1) begin
      b1_q <= in_data_i.rx_byte;
    end
  end

endmodule

`default_nettype wire

/* design/pmct_queue.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker packet queue
// Small FIFO of complete packets between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_cursor_tracker_assert.svh"

module pmct_queue #(
  parameter int unsigned Depth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pmct_pkg::pmct_pkt_t  push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output pmct_pkg::pmct_pkt_t       head_o,
  output logic                      empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  pmct_pkg::pmct_pkt_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store pushed packets
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `PMCT_ASSERT_NOW(q_no_overflow, clk_i, rst_ni, push_i, !full_o, "push into full queue")
  `PMCT_ASSERT_NOW(q_no_underflow, clk_i, rst_ni, pop_i, !empty_o, "pop from empty queue")
  `PMCT_ASSERT_NEXT(q_pop_count, clk_i, rst_ni, pop_i && !push_i, cnt_q == $past(cnt_q) - CntW'(1), "fill count did not drop on pop")

endmodule

`default_nettype wire

/* design/pmct_back.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker back end
// Applies packet deltas to the cursor, clamps to the screen, registers result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "ps2_mouse_cursor_tracker_assert.svh"

module pmct_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire pmct_pkg::pmct_scr_t  scr_i,
  input  wire pmct_pkg::pmct_pkt_t  pkt_i,
  input  wire logic                 empty_i,
  output logic                      pop_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pmct_pkg::pmct_out_t       out_data_o
);

  logic [6:0]        col_q, col_d;
  logic [4:0]        row_q, row_d;
  logic [2:0]        prev_btn_q;
  logic              out_valid_q, out_valid_d;
  pmct_pkg::pmct_out_t out_q;
  logic signed [9:0] dx, dy, col_sum, row_sum;

  // Pop when the output register is free or being drained
  assign pop_o = !empty_i && (!out_valid_q || !out_stall_i);

  // Sign-extend 9-bit deltas and form full-width sums
  assign dx      = {{2{pkt_i.btn[pmct_pkg::XSIGN_BIT]}}, pkt_i.dx};
  assign dy      = {{2{pkt_i.btn[pmct_pkg::YSIGN_BIT]}}, pkt_i.dy};
  assign col_sum = $signed({3'b000, col_q}) + dx;
  assign row_sum = $signed({5'b00000, row_q}) - dy;

  // Clamp to the screen
  always_comb begin
    logic [6:0] rclamp;
    rclamp = pmct_pkg::clamp_pos(row_sum, {2'b00, scr_i.rows});
    col_d  = pmct_pkg::clamp_pos(col_sum, scr_i.cols);
    row_d  = rclamp[4:0];
  end

  // Load, hold or drain the result
  always_comb begin
    out_valid_d = out_valid_q;
    if (pop_o) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= pmct_pkg::COL_RESET;
      row_q       <= pmct_pkg::ROW_RESET;
      prev_btn_q  <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        col_q      <= col_d;
        row_q      <= row_d;
        prev_btn_q <= pkt_i.btn[2:0];
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q.old_col         <= col_q;
      out_q.old_row         <= row_q;
      out_q.new_col         <= col_d;
      out_q.new_row         <= row_d;
      out_q.button_byte     <= pkt_i.btn;
      out_q.changed_buttons <= pkt_i.btn[2:0] ^ prev_btn_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `PMCT_ASSERT_NEXT(bk_cursor_track, clk_i, rst_ni, pop_o, out_valid_q && col_q == out_q.new_col && row_q == out_q.new_row, "cursor not updated from result")
  `PMCT_ASSERT_NEXT(bk_btn_track, clk_i, rst_ni, pop_o, prev_btn_q == out_q.button_byte[2:0], "button history not updated")

endmodule

`default_nettype wire

/* design/ps2_mouse_cursor_tracker.sv */
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker
// Gathers PS/2 mouse bytes into packets and tracks a clamped text cursor.
//
//   channel   dir   handshake                 payload
//   in        in    in_valid_i / in_stall_o   in_data_i  (pmct_in_t)
//   out       out   out_valid_o / out_stall_i out_data_o (pmct_out_t)
//   cfg       in    cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One byte is taken per cycle while in_stall_o is low. A packet's third byte
// enters the queue; its result is registered when the back end pops it. The
// back end's single add-and-clamp retires one packet per cycle when unstalled.
// Reset (async, low) sets the cursor to column 40, row 12 and an 80 x 25 screen.
// in_stall_o rises only while the packet queue is full, which happens when
// out_stall_i holds the result register and further packets pile up.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_cursor_tracker #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire pmct_pkg::pmct_in_t   in_data_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output pmct_pkg::pmct_out_t       out_data_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [0:0]           cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i
);

  logic [7:0]          cols_q;
  logic [5:0]          rows_q;
  pmct_pkg::pmct_scr_t scr;
  logic                push, pop, full, empty;
  pmct_pkg::pmct_pkt_t push_pkt, head_pkt;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= pmct_pkg::COLS_RESET;
      rows_q <= pmct_pkg::ROWS_RESET;
    end else if (cfg_we_i) begin
      case (pmct_pkg::pmct_cfg_e'(cfg_idx_i))
        pmct_pkg::CFG_SCREEN_COLS: cols_q <= cfg_wdata_i;
        pmct_pkg::CFG_SCREEN_ROWS: rows_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Limit screen size to its legal range
  always_comb begin
    scr.cols = cols_q;
    if (cols_q == 8'd0) begin
      scr.cols = 8'd1;
    end else if (cols_q > pmct_pkg::COLS_MAX) begin
      scr.cols = pmct_pkg::COLS_MAX;
    end
    scr.rows = rows_q;
    if (rows_q == 6'd0) begin
      scr.rows = 6'd1;
    end else if (rows_q > pmct_pkg::ROWS_MAX) begin
      scr.rows = pmct_pkg::ROWS_MAX;
    end
  end

  pmct_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .pkt_o      (push_pkt),
    .full_i     (full)
  );

  pmct_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_pkt),
    .full_o      (full),
    .pop_i       (pop),
    .head_o      (head_pkt),
    .empty_o     (empty)
  );

  pmct_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .scr_i       (scr),
    .pkt_i       (head_pkt),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

/* verif/ps2_mouse_cursor_tracker_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PS/2 mouse cursor tracker testbench
// Feeds controller bytes, mouse and non-mouse, into the tracker and checks
// every cursor move report against a cycle-free packet decoder kept in step
// with the accepted items. Covers edge moves, screen size extremes, random
// packets under three idling mixes, and a long output hold.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned LIMIT_CYCLES  = 200_000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned MAX_REPORTS   = 10;

  // Block ports
  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic                in_stall_o;
  pmct_pkg::pmct_in_t  in_data_i   = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  pmct_pkg::pmct_out_t out_data_o;
  logic                cfg_we_i    = 1'b0;
  logic [0:0]          cfg_idx_i   = '0;
  logic [7:0]          cfg_wdata_i = '0;

  // Decoder state, kept in step with accepted items
  logic [1:0] byte_pos  = '0;
  logic [7:0] pkt_hold [2];
  logic [6:0] cur_col   = pmct_pkg::COL_RESET;
  logic [4:0] cur_row   = pmct_pkg::ROW_RESET;
  logic [2:0] prev_btn  = '0;
  logic [7:0] scr_cols  = pmct_pkg::COLS_RESET;
  logic [5:0] scr_rows  = pmct_pkg::ROWS_RESET;

  pmct_pkg::pmct_out_t cursor_moves_q [$];
  pmct_pkg::pmct_out_t exp_move;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;

  // Idling controls
  int unsigned send_idle_pct   = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned hold_cycles_req = 0;
  int unsigned hold_left       = 0;

  ps2_mouse_cursor_tracker DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("ps2_mouse_cursor_tracker: mismatch");
      $finish;
    end
  end

  function automatic int limit_to_screen(int v, int n);
    if (v < 0) return 0;
    if (v >= n) return n - 1;
    return v;
  endfunction

  // Advance the decoder by one accepted byte; queue a move report on packet end
  task automatic decode_byte(pmct_pkg::pmct_in_t it);
    int                  n_cols, n_rows, dx, dy, c, r;
    pmct_pkg::pmct_out_t mv;
    if (!it.from_mouse) return;
    if (byte_pos < pmct_pkg::LAST_BYTE) begin
      pkt_hold[byte_pos] = it.rx_byte;
      byte_pos++;
      return;
    end
    byte_pos = '0;
    n_cols = (scr_cols == 0) ? 1 :
             ((scr_cols > pmct_pkg::COLS_MAX) ? int'(pmct_pkg::COLS_MAX) : int'(scr_cols));
    n_rows = (scr_rows == 0) ? 1 :
             ((scr_rows > pmct_pkg::ROWS_MAX) ? int'(pmct_pkg::ROWS_MAX) : int'(scr_rows));
    dx = int'(pkt_hold[1]) - (pkt_hold[0][pmct_pkg::XSIGN_BIT] ? 256 : 0);
    dy = int'(it.rx_byte) - (pkt_hold[0][pmct_pkg::YSIGN_BIT] ? 256 : 0);
    c = limit_to_screen(int'(cur_col) + dx, n_cols);
    r = limit_to_screen(int'(cur_row) - dy, n_rows);
    mv.old_col         = cur_col;
    mv.old_row         = cur_row;
    mv.new_col         = 7'(c);
    mv.new_row         = 5'(r);
    mv.button_byte     = pkt_hold[0];
    mv.changed_buttons = pkt_hold[0][2:0] ^ prev_btn;
    cursor_moves_q.push_back(mv);
    cur_col  = 7'(c);
    cur_row  = 5'(r);
    prev_btn = pkt_hold[0][2:0];
  endtask

  task automatic note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_REPORTS)
      $display("%0t: %s expected %0d got %0d", $time, what, exp_v, act_v);
  endtask

  // Check each accepted move report against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (cursor_moves_q.size() == 0) begin
        note_mismatch("unexpected item", 0, 32'(out_data_o.button_byte));
      end else begin
        exp_move = cursor_moves_q.pop_front();
        if (exp_move.old_col != out_data_o.old_col)
          note_mismatch("old_col", exp_move.old_col, out_data_o.old_col);
        if (exp_move.old_row != out_data_o.old_row)
          note_mismatch("old_row", exp_move.old_row, out_data_o.old_row);
        if (exp_move.new_col != out_data_o.new_col)
          note_mismatch("new_col", exp_move.new_col, out_data_o.new_col);
        if (exp_move.new_row != out_data_o.new_row)
          note_mismatch("new_row", exp_move.new_row, out_data_o.new_row);
        if (exp_move.button_byte != out_data_o.button_byte)
          note_mismatch("button_byte", exp_move.button_byte, out_data_o.button_byte);
        if (exp_move.changed_buttons != out_data_o.changed_buttons)
          note_mismatch("changed_buttons", exp_move.changed_buttons,
                        out_data_o.changed_buttons);
      end
    end
  end

  // Drive the output stall: a requested long hold first, else random stalls
  always @(negedge clk_i) begin
    if (hold_cycles_req != 0) begin
      hold_left       = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Offer one item, idling cycle by cycle at random, and hold it until accepted
  task automatic send_byte(logic [7:0] b, logic mouse);
    pmct_pkg::pmct_in_t it;
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    it.rx_byte    = b;
    it.from_mouse = mouse;
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(it);
  endtask

  // Send one three-byte packet, with non-mouse noise slipped in at random
  task automatic send_packet(logic [7:0] btn, logic [7:0] dx, logic [7:0] dy,
                             int unsigned noise_pct);
    logic [7:0] bytes [3];
    bytes = '{btn, dx, dy};
    foreach (bytes[i]) begin
      if (noise_pct != 0 && $urandom_range(99) < noise_pct)
        send_byte(8'($urandom_range(255)), 1'b0);
      send_byte(bytes[i], 1'b1);
    end
  endtask

  // Drop valid, let every report drain and the pipeline settle
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (cursor_moves_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_screen(pmct_pkg::pmct_cfg_e idx, logic [7:0] val);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      pmct_pkg::CFG_SCREEN_COLS: scr_cols = val;
      pmct_pkg::CFG_SCREEN_ROWS: scr_rows = val[5:0];
      default: ;
    endcase
  endtask

  // Pick a screen size, often at or past an extreme
  task automatic randomize_screen();
    logic [7:0] cols, rows;
    case ($urandom_range(7))
      0: cols = 8'd0;
      1: cols = 8'd1;
      2: cols = pmct_pkg::COLS_MAX;
      3: cols = 8'hFF;
      default: cols = 8'($urandom_range(128, 1));
    endcase
    case ($urandom_range(7))
      0: rows = 8'd0;
      1: rows = 8'd1;
      2: rows = 8'(pmct_pkg::ROWS_MAX);
      3: rows = 8'hFF;
      default: rows = {2'($urandom_range(3)), 6'($urandom_range(32, 1))};
    endcase
    write_screen(pmct_pkg::CFG_SCREEN_COLS, cols);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, rows);
  endtask

  // Mostly small moves so the cursor wanders inside the screen
  function automatic logic [8:0] pick_delta();
    int v;
    if ($urandom_range(99) < 70) v = int'($urandom_range(16)) - 8;
    else v = int'($urandom_range(511));
    return 9'(v);
  endfunction

  task automatic send_random_packet(int unsigned noise_pct);
    logic [8:0] dx9, dy9;
    logic [7:0] btn;
    dx9 = pick_delta();
    dy9 = pick_delta();
    btn = 8'($urandom_range(255));
    btn[pmct_pkg::XSIGN_BIT] = dx9[8];
    btn[pmct_pkg::YSIGN_BIT] = dy9[8];
    send_packet(btn, dx9[7:0], dy9[7:0], noise_pct);
  endtask

  // Edge moves from the reset screen, button changes, noise inside a packet
  task automatic test_directed_moves();
    send_byte(8'h00, 1'b0);
    send_packet(8'h08, 8'h00, 8'h00, 0);
    send_byte(8'hFF, 1'b0);
    send_packet(8'h08, 8'hFF, 8'h00, 0);
    send_byte(8'h3F, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'hAA, 1'b0);
    send_byte(8'h00, 1'b1);
    send_packet(8'hC8, 8'h01, 8'hFF, 0);
  endtask

  // Zero and oversize screen values, then a screen shrunk under the cursor
  task automatic test_screen_limits();
    write_screen(pmct_pkg::CFG_SCREEN_COLS, 8'd0);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, 8'd0);
    send_packet(8'h08, 8'h00, 8'h00, 0);
    write_screen(pmct_pkg::CFG_SCREEN_COLS, 8'hFF);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, 8'hFF);
    send_packet(8'h28, 8'hFF, 8'h00, 0);
    write_screen(pmct_pkg::CFG_SCREEN_COLS, 8'd10);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, 8'd5);
    send_packet(8'h08, 8'h00, 8'h00, 0);
  endtask

  task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct);
    int unsigned mouse_bytes, n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    mouse_bytes   = 0;
    while (mouse_bytes < 280) begin
      if ($urandom_range(39) == 0) randomize_screen();
      if ($urandom_range(19) == 0) begin
        // stray mouse bytes shift the packet framing
        n = $urandom_range(2, 1);
        repeat (n) send_byte(8'($urandom_range(255)), 1'b1);
        mouse_bytes += n;
      end else begin
        send_random_packet(8);
        mouse_bytes += 3;
      end
    end
  endtask

  task automatic test_random_packets();
    randomize_screen();
    run_random_phase(13, 56);
    randomize_screen();
    run_random_phase(56, 13);
    randomize_screen();
    run_random_phase(0, 0);
  endtask

  // Hold the output for a long stretch while packets keep coming
  task automatic test_backpressure();
    write_screen(pmct_pkg::CFG_SCREEN_COLS, pmct_pkg::COLS_MAX);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, 8'(pmct_pkg::ROWS_MAX));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random_packet(0);
    hold_cycles_req = 300;
    repeat (40) send_random_packet(0);
    write_screen(pmct_pkg::CFG_SCREEN_COLS, 8'd1);
    write_screen(pmct_pkg::CFG_SCREEN_ROWS, 8'd1);
    repeat (3) send_random_packet(0);
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed_moves();
    test_screen_limits();
    test_random_packets();
    test_backpressure();
    wait_idle();
    if (mismatch_cnt == 0 && cursor_moves_q.size() == 0) begin
      $display("ps2_mouse_cursor_tracker: match");
    end else begin
      $display("ps2_mouse_cursor_tracker: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+design
design/pmct_pkg.sv
design/pmct_front.sv
design/pmct_queue.sv
design/pmct_back.sv
design/ps2_mouse_cursor_tracker.sv
verif/ps2_mouse_cursor_tracker_tb.sv
